// ===== sv/swa_pkg.sv =====
// shared types and constants of the sliding window average block
`timescale 1ns / 1ps

package swa_pkg;

  localparam int SAMPLE_W  = 16;           // sample and average width
  localparam int SUM_W     = 21;           // running sum width, signed
  localparam int CNT_W     = 5;            // window size and stored count width
  localparam int REM_W     = CNT_W + 1;    // divider partial remainder width
  localparam int STEP_W    = 5;            // divider step counter width
  localparam int DIV_STEPS = SUM_W;        // one quotient bit per step
  localparam int WIN_RESET = 3;            // window size after reset

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [SUM_W-1:0]    mag_t;
  typedef logic        [CNT_W-1:0]    cnt_t;
  typedef logic        [REM_W-1:0]    rem_t;
  typedef logic        [STEP_W-1:0]   step_t;

endpackage

// ===== sv/sliding_window_average.sv =====
// sliding window average: ring store of samples, running sum, serial divider
`timescale 1ns / 1ps

// Usage
//   input channel  : in_valid / in_stall, word = sample (signed 16 bits)
//   output channel : out_valid / out_stall, word = average (signed 16 bits)
//                    and window_full
//   config channel : cfg_valid / cfg_ready, word = window_size; a write clamps
//                    the size to 1..MAX_WINDOW and empties the window
// Each input word yields exactly one output word. A word is taken only while
// the sequencer is idle and no window write is offered, then goes through:
// store read, oldest-sample removal and store write, add of the new sample,
// magnitude, 21 steps of a restoring divider (one quotient bit per cycle)
// and the load of the output register.
// A new word is taken only once the sequencer has loaded the previous result
// into the output register and returned to idle.
// The output register decouples the sides: while a result waits under
// out_stall the block still takes the next word, and it holds that one's
// result in its last step until the output register frees up.
// Reset (rst, synchronous) sets the window size to 3 and empties the window;
// the sample store itself is not cleared, only entries written since the
// last clear are ever read back.
module sliding_window_average #(
  parameter int MAX_WINDOW = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  // sample input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [swa_pkg::SAMPLE_W-1:0] sample,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [swa_pkg::SAMPLE_W-1:0] average,
  output logic                            window_full,
  // window size register
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swa_pkg::CNT_W-1:0]       window_size
);

  localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_MAX = (1 << swa_pkg::CNT_W) - 1;
  localparam int WIN_CAP = (MAX_WINDOW > CNT_MAX) ? CNT_MAX : MAX_WINDOW;
  localparam int WIN_RST = (MAX_WINDOW < swa_pkg::WIN_RESET) ? MAX_WINDOW
                                                             : swa_pkg::WIN_RESET;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a word
  localparam logic [2:0] ST_READ = 3'd1;  // oldest sample out, new one stored
  localparam logic [2:0] ST_ADD  = 3'd2;  // new sample into sum, count/position
  localparam logic [2:0] ST_ABS  = 3'd3;  // sign and magnitude of the sum
  localparam logic [2:0] ST_DIV  = 3'd4;  // one quotient bit per cycle
  localparam logic [2:0] ST_DONE = 3'd5;  // sign fix, load output register

  logic [2:0]          state;
  swa_pkg::cnt_t       win_size;
  swa_pkg::cnt_t       count;
  logic [AW-1:0]       pos;
  swa_pkg::sum_t       sum;
  swa_pkg::sample_t    smp;
  logic                full;      // window was full when this word arrived
  logic                neg;       // sum was negative
  swa_pkg::mag_t       quo;       // dividend shifting out, quotient shifting in
  swa_pkg::rem_t       rem;
  swa_pkg::step_t      step;

  swa_pkg::sample_t    old_smp;
  logic                in_acc;
  logic                cfg_acc;
  logic                out_load;
  swa_pkg::cnt_t       win_clamped;
  logic [AW:0]         pos_inc;
  swa_pkg::rem_t       rem_sh;
  logic                rem_ge;
  swa_pkg::mag_t       quo_signed;

  // an offered window write goes first, the input waits for it
  assign in_stall  = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  // clamp the written size into 1..MAX_WINDOW
  always_comb begin
    priority if (32'(window_size) > 32'(MAX_WINDOW)) begin
      win_clamped = swa_pkg::CNT_W'(WIN_CAP);
    end else if (window_size == '0) begin
      win_clamped = swa_pkg::CNT_W'(1);
    end else begin
      win_clamped = window_size;
    end
  end

  assign pos_inc = {1'b0, pos} + (AW+1)'(1);

  // restoring divide step on the magnitude
  assign rem_sh = {rem[swa_pkg::REM_W-2:0], quo[swa_pkg::SUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, count});

  assign quo_signed = neg ? (~quo + swa_pkg::SUM_W'(1)) : quo;

  // sample ring store
  swa_ram #(
    .WIDTH (swa_pkg::SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (state == ST_READ),
    .waddr (pos),
    .wdata (smp),
    .re    (in_acc),
    .raddr (pos),
    .rdata (old_smp)
  );

  // control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      win_size <= swa_pkg::CNT_W'(WIN_RST);
      count    <= '0;
      pos      <= '0;
      sum      <= '0;
      step     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cfg_acc) begin
            win_size <= win_clamped;
            count    <= '0;
            pos      <= '0;
            sum      <= '0;
          end else if (in_acc) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          // drop the oldest sample once the window is full
          if (full) begin
            sum <= sum - swa_pkg::sum_t'(old_smp);
          end
          state <= ST_ADD;
        end
        ST_ADD: begin
          sum <= sum + swa_pkg::sum_t'(smp);
          if (!full) begin
            count <= count + swa_pkg::CNT_W'(1);
          end
          if (32'(pos_inc) >= 32'(win_size)) begin
            pos <= '0;
          end else begin
            pos <= pos_inc[AW-1:0];
          end
          state <= ST_ABS;
        end
        ST_ABS: begin
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + swa_pkg::STEP_W'(1);
          if (step == swa_pkg::STEP_W'(swa_pkg::DIV_STEPS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp  <= sample;
      full <= (count == win_size);
    end
    if (state == ST_ABS) begin
      neg <= sum[swa_pkg::SUM_W-1];
      quo <= sum[swa_pkg::SUM_W-1] ? swa_pkg::mag_t'(-sum) : swa_pkg::mag_t'(sum);
      rem <= '0;
    end else if (state == ST_DIV) begin
      rem <= rem_ge ? (rem_sh - {1'b0, count}) : rem_sh;
      quo <= {quo[swa_pkg::SUM_W-2:0], rem_ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average     <= quo_signed[swa_pkg::SAMPLE_W-1:0];
      window_full <= (count == win_size);
    end
  end

  // checks
  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    count <= win_size)
    else $error("stored count exceeds window size");

  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    32'(pos) < 32'(win_size))
    else $error("write position outside window");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (count != '0))
    else $error("divide with empty window");

  a_size_clamped: assert property (@(posedge clk) disable iff (rst)
    (win_size != '0) && (32'(win_size) <= 32'(MAX_WINDOW)))
    else $error("window size out of range");

  a_load_returns_idle: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state == ST_IDLE) && out_valid)
    else $error("result load did not free the sequencer");

endmodule

// ===== sv/swa_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/tb_sliding_window_average.sv =====
// self-checking testbench for the sliding window average block
`timescale 1ns / 1ps

module tb_sliding_window_average;

  localparam int MAX_WINDOW  = 20;
  localparam int CYCLE_LIMIT = 500000;  // far above the slowest legal run
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int DRAIN       = 60;      // quiet cycles after the last result
  localparam int PHASE_WORDS = 280;     // random sample words per idling phase, at least

  // one result word of the block
  typedef struct {
    swa_pkg::sample_t average;
    logic             full;
  } avg_word_t;

  // directed table: either a window write or a sample with an optional
  // hand-typed result
  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        value;
    bit        typed;
    int        avg;
    bit        full;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  swa_pkg::sample_t sample;
  logic             out_valid;
  logic             out_stall;
  swa_pkg::sample_t average;
  logic             window_full;
  logic             cfg_valid;
  logic             cfg_ready;
  swa_pkg::cnt_t    window_size;

  sliding_window_average #(
    .MAX_WINDOW(MAX_WINDOW)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .average    (average),
    .window_full(window_full),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .window_size(window_size)
  );

  // predictor state: ring of samples, position, fill count, running sum
  swa_pkg::sample_t win_store [MAX_WINDOW];
  int unsigned      win_pos;
  int unsigned      win_count;
  int unsigned      win_len;
  int               win_sum;

  // results still owed by the block, oldest first
  avg_word_t pending_averages[$];

  int  error_count;
  int  words_sent;
  int  results_seen;
  int  window_writes;
  int  cycle_count;
  int  send_idle;        // percent of cycles the sender sits idle
  int  recv_idle;        // percent of cycles the receiver stalls
  bit  hold_request;     // asks the stall process for one long hold-off

  dir_row_t directed_rows [18];

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // window write: clamp to 1..MAX_WINDOW and empty the window
  function automatic void apply_window(swa_pkg::cnt_t v);
    if (v == 0)
      win_len = 1;
    else if (v > MAX_WINDOW)
      win_len = MAX_WINDOW;
    else
      win_len = v;
    win_pos   = 0;
    win_count = 0;
    win_sum   = 0;
  endfunction

  // take one sample into the window and work out the average it yields
  function automatic avg_word_t average_after(swa_pkg::sample_t s);
    avg_word_t   r;
    int unsigned p;
    p = win_pos;
    if (p >= win_len)
      p = 0;
    // still filling: append; full: drop the oldest from the sum first
    if (win_count < win_len)
      win_count++;
    else
      win_sum -= win_store[p];
    win_store[p] = s;
    win_sum += s;
    p++;
    if (p >= win_len)
      p = 0;
    win_pos = p;
    // int division truncates toward zero, as the block must
    r.average = swa_pkg::sample_t'(win_sum / int'(win_count));
    r.full    = (win_count == win_len);
    return r;
  endfunction

  // random window value, weighted toward the extremes and the clamped codes
  function automatic swa_pkg::cnt_t pick_window();
    case ($urandom_range(7))
      0:       return swa_pkg::cnt_t'(1);
      1:       return swa_pkg::cnt_t'(MAX_WINDOW);
      2:       return swa_pkg::cnt_t'(0);
      3:       return swa_pkg::cnt_t'($urandom_range(31, MAX_WINDOW + 1));
      default: return swa_pkg::cnt_t'($urandom_range(MAX_WINDOW, 1));
    endcase
  endfunction

  // random sample: full-scale rails, small values near zero, or anything
  function automatic swa_pkg::sample_t pick_sample();
    case ($urandom_range(9))
      0:       return swa_pkg::sample_t'(16'h7fff);
      1:       return swa_pkg::sample_t'(16'h8000);
      2, 3:    return swa_pkg::sample_t'($urandom_range(200) - 100);
      default: return swa_pkg::sample_t'($urandom);
    endcase
  endfunction

  // offer one sample word; entered and left at a falling edge
  task automatic send_word(input swa_pkg::sample_t s, input bit typed,
                           input avg_word_t typed_exp);
    avg_word_t predicted;
    // random idle cycles before the word goes out
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    // word accepted at this edge
    predicted = average_after(s);
    pending_averages.push_back(typed ? typed_exp : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  // drop the input valid and wait for every owed result to come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_averages.size() != 0)
      @(negedge clk);
  endtask

  // one write on the window size register; entered and left at a falling edge
  task automatic write_window(input swa_pkg::cnt_t v);
    cfg_valid   <= 1'b1;
    window_size <= v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    apply_window(v);
    window_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver stall: random per cycle, or a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // compare every accepted result word with the oldest owed one
  always @(posedge clk) begin
    avg_word_t owed;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_averages.size() == 0) begin
        $error("result word with nothing owed: average %0d window_full %0b",
               average, window_full);
        error_count++;
      end else begin
        owed = pending_averages.pop_front();
        if (average !== owed.average) begin
          $error("average: expected %0d, actual %0d", owed.average, average);
          error_count++;
        end
        if (window_full !== owed.full) begin
          $error("window_full: expected %0b, actual %0b", owed.full, window_full);
          error_count++;
        end
      end
    end
  end

  initial begin
    avg_word_t typed_exp;
    int        n;
    bit        pressure_done;
    int        phase_sent;

    // every input known from time zero
    rst          = 1'b1;
    in_valid     = 1'b0;
    sample       = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    window_size  = '0;
    hold_request = 1'b0;
    error_count  = 0;
    words_sent   = 0;
    results_seen = 0;
    window_writes = 0;
    cycle_count  = 0;
    send_idle    = 14;
    recv_idle    = 74;
    pressure_done = 1'b0;
    apply_window(swa_pkg::cnt_t'(swa_pkg::WIN_RESET));

    // directed words; typed results follow from the window rules directly
    directed_rows = '{
      // reset window of three: fill it from both rails, then wrap
      '{ROW_SAMPLE,  32767, 1,  32767, 0},
      '{ROW_SAMPLE, -32768, 1,      0, 0},  // -1 / 2 truncates to zero
      '{ROW_SAMPLE,      0, 1,      0, 1},
      '{ROW_SAMPLE,    100, 1, -10889, 1},  // oldest rail sample dropped
      // zero written: clamps to a window of one
      '{ROW_WINDOW,      0, 0,      0, 0},
      '{ROW_SAMPLE,     -5, 1,     -5, 1},
      '{ROW_SAMPLE,      7, 1,      7, 1},
      // all ones written: clamps to the largest window
      '{ROW_WINDOW,     31, 0,      0, 0},
      '{ROW_SAMPLE, -32768, 1, -32768, 0},
      '{ROW_SAMPLE, -32768, 1, -32768, 0},
      '{ROW_SAMPLE,  32767, 1, -10923, 0},
      // window of two: negative averages truncate toward zero
      '{ROW_WINDOW,      2, 0,      0, 0},
      '{ROW_SAMPLE,      1, 1,      1, 0},
      '{ROW_SAMPLE,     -2, 1,      0, 1},
      '{ROW_SAMPLE,     -3, 1,     -2, 1},
      // just above the largest window
      '{ROW_WINDOW,     21, 0,      0, 0},
      '{ROW_SAMPLE,      9, 1,      9, 0},
      '{ROW_SAMPLE, -32768, 0,      0, 0}
    };

    // hold reset, then release it on a falling edge
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WINDOW) begin
        wait_idle();
        write_window(swa_pkg::cnt_t'(directed_rows[i].value));
      end else begin
        typed_exp.average = swa_pkg::sample_t'(directed_rows[i].avg);
        typed_exp.full    = directed_rows[i].full;
        send_word(swa_pkg::sample_t'(directed_rows[i].value), directed_rows[i].typed,
                  typed_exp);
      end
    end

    // random part: three idling phases, each a run of window segments
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 14;
          recv_idle = 74;
        end
        1: begin
          send_idle = 74;
          recv_idle = 14;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      phase_sent = 0;
      while (phase_sent < PHASE_WORDS) begin
        wait_idle();
        write_window(pick_window());
        // once, with no idling, park the receiver so the block backs up
        if (phase == 2 && !pressure_done && phase_sent > 100) begin
          hold_request  = 1'b1;
          pressure_done = 1'b1;
        end
        n = $urandom_range(50, 8);
        repeat (n) begin
          send_word(pick_sample(), 1'b0, typed_exp);
          phase_sent++;
        end
      end
    end

    // let the last results out, then a quiet stretch for stray words
    wait_idle();
    repeat (DRAIN) @(negedge clk);

    $display("covered %0d sample words over %0d window writes, %0d result words checked",
             words_sent, window_writes, results_seen);
    $display("idling phases: sender-light, receiver-light, none; one long output hold-off");
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
